FILE: hw/rtl/b64d_pkg.sv
// types, constants and the character classifier shared by the base64 decoder
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharPad     = 8'h3d;  // '='
  localparam logic [7:0] CharPlus    = 8'h2b;
  localparam logic [7:0] CharSlash   = 8'h2f;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharDigit0  = 8'h30;
  localparam logic [7:0] LowerOffset = 8'd26;
  localparam logic [7:0] DigitOffset = 8'd52;
  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  typedef enum logic [1:0] {
    CLS_SEXTET,
    CLS_PAD,
    CLS_BAD
  } sym_class_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_PAD  = 2'd2,
    STATUS_BAD_LEN  = 2'd3
  } status_e;

  typedef struct packed {
    sym_class_e cls;
    logic [5:0] sextet;
  } sym_t;

  typedef struct packed {
    sym_class_e cls;
    logic [5:0] sextet;
    logic       last;
  } item_t;

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    s.cls    = CLS_SEXTET;
    s.sextet = '0;
    case (c) inside
      [8'h41:8'h5a]: s.sextet = 6'(c - CharUpperA);
      [8'h61:8'h7a]: s.sextet = 6'(c - CharLowerA + LowerOffset);
      [8'h30:8'h39]: s.sextet = 6'(c - CharDigit0 + DigitOffset);
      CharPlus:      s.sextet = SextetPlus;
      CharSlash:     s.sextet = SextetSlash;
      CharPad:       s.cls    = CLS_PAD;
      default:       s.cls    = CLS_BAD;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64d_front.sv
// front stage: takes characters, classifies them and holds one classified word
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      symbol_i,
  input  wire logic            last_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 item_valid_o,
  output b64d_pkg::item_t      item_o,
  input  wire logic            item_ready_i
);

  logic            valid_q, valid_d;
  b64d_pkg::item_t item_q;
  b64d_pkg::sym_t  sym;
  logic            accept;

  assign sym        = b64d_pkg::classify(symbol_i);
  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cls    <= sym.cls;
      item_q.sextet <= sym.sextet;
      item_q.last   <= last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/b64d_queue.sv
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  input  b64d_pkg::item_t      push_item_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output b64d_pkg::item_t      pop_item_o,
  input  wire logic            pop_ready_i
);

  b64d_pkg::item_t mem [b64d_pkg::QueueDepth];

  logic [b64d_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [b64d_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [b64d_pkg::QueueCntW-1:0] count_q, count_d;
  logic                           push, pop;

  assign push_ready_o = count_q != b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem[rd_ptr_q];

  function automatic logic [b64d_pkg::QueuePtrW-1:0] ptr_inc(
    input logic [b64d_pkg::QueuePtrW-1:0] p
  );
    logic [b64d_pkg::QueuePtrW-1:0] n;
    n = p + 1'b1;
    if (p == b64d_pkg::QueuePtrW'(b64d_pkg::QueueDepth - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth))
    |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/b64d_back.sv
// back stage: bit accumulator, length and padding checks, output register
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  b64d_pkg::item_t      item_i,
  output logic                 item_ready_o,
  output logic [7:0]           data_byte_o,
  output logic                 byte_valid_o,
  output logic                 is_last_o,
  output logic [1:0]           status_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i
);

  logic [11:0] buf_q, buf_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  content_q, content_d;
  logic [1:0]  total_q, total_d;
  logic [1:0]  pad_q, pad_d;
  logic        err_q, err_d;

  logic              out_valid_q;
  logic [7:0]        byte_q, byte_d;
  logic              bvalid_q, bvalid_d;
  logic              last_q;
  b64d_pkg::status_e status_q, status_d;

  logic        take;
  logic [11:0] acc;
  logic [3:0]  n;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign acc          = {buf_q[5:0], item_i.sextet};
  assign n            = {1'b0, cnt_q} + 4'd6;

  always_comb begin
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    content_d = content_q;
    total_d   = total_q + 1'b1;
    pad_d     = pad_q;
    err_d     = err_q;
    byte_d    = '0;
    bvalid_d  = 1'b0;
    status_d  = b64d_pkg::STATUS_OK;

    case (item_i.cls)
      b64d_pkg::CLS_PAD: begin
        if (pad_q != 2'd3) begin
          pad_d = pad_q + 1'b1;
        end
      end
      b64d_pkg::CLS_SEXTET: begin
        if (pad_q != '0) begin
          err_d = 1'b1;  // '=' followed by content
        end
        pad_d     = '0;
        content_d = total_d;
        buf_d     = acc;
        cnt_d     = n[2:0];
        if (n >= 4'd8) begin
          bvalid_d = 1'b1;
          cnt_d    = 3'(n - 4'd8);
          case (cnt_d)
            3'd2:    byte_d = acc[9:2];
            3'd4:    byte_d = acc[11:4];
            default: byte_d = acc[7:0];
          endcase
        end
      end
      default: begin
        if (pad_q != '0) begin
          err_d = 1'b1;
        end
        pad_d     = '0;
        content_d = total_d;
        err_d     = 1'b1;
      end
    endcase

    if (item_i.last) begin
      if (pad_d == 2'd3 || (pad_d != '0 && total_d != '0)) begin
        status_d = b64d_pkg::STATUS_BAD_PAD;
      end else if (content_d == 2'd1) begin
        status_d = b64d_pkg::STATUS_BAD_LEN;
      end else if (err_d) begin
        status_d = b64d_pkg::STATUS_BAD_CHAR;
      end
      // message done: back to the idle state
      buf_d     = '0;
      cnt_d     = '0;
      content_d = '0;
      total_d   = '0;
      pad_d     = '0;
      err_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      content_q   <= '0;
      total_q     <= '0;
      pad_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        buf_q     <= buf_d;
        cnt_q     <= cnt_d;
        content_q <= content_d;
        total_q   <= total_d;
        pad_q     <= pad_d;
        err_q     <= err_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      last_q   <= item_i.last;
      status_q <= status_d;
    end
  end

  assign data_byte_o  = byte_q;
  assign byte_valid_o = bvalid_q;
  assign is_last_o    = last_q;
  assign status_o     = status_q;
  assign out_valid_o  = out_valid_q;

`ifndef ASSERT_OFF
  a_cnt_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] == 1'b0)
    else $error("bit count is odd");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.last) |=> (cnt_q == '0 && total_q == '0 && pad_q == '0 && !err_q))
    else $error("state not cleared after last word");
  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_last_o) |-> status_o == b64d_pkg::STATUS_OK)
    else $error("status set on a word that is not last");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/base64_strict_decoder_unit.sv
// path: front register, then a queue entry, then the back output register
// throughput: one character per cycle unless out_ready_i stalls the back stage
// the two-entry queue lets front and back stall independently
// reset: rst_ni is asynchronous, active low, and clears all message state
// no clearing pass; the block takes characters in the first cycle after reset
`timescale 1ns / 1ps
`default_nettype none

module base64_strict_decoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] symbol_i,
  input  wire logic       last_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic [7:0]      data_byte_o,
  output logic            byte_valid_o,
  output logic            is_last_o,
  output logic [1:0]      status_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);

  logic            fe_valid, fe_ready;
  b64d_pkg::item_t fe_item;
  logic            q_valid, q_ready;
  b64d_pkg::item_t q_item;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .symbol_i     (symbol_i),
    .last_i       (last_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_valid_o (fe_valid),
    .item_o       (fe_item),
    .item_ready_i (fe_ready)
  );

  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_item_i  (fe_item),
    .push_ready_o (fe_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_ready_o (q_ready),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .is_last_o    (is_last_o),
    .status_o     (status_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

`default_nettype wire

FILE: sim/tb_base64_strict_decoder_unit.sv
// self-checking testbench for the strict base64 decoder unit
`timescale 1ns / 1ps

module tb_base64_strict_decoder_unit;

  typedef struct packed {
    logic [7:0]          data;
    logic                bv;
    logic                lst;
    b64d_pkg::status_e   st;
  } dec_word_t;

  // directed row: character, last mark, and a typed word where one is given
  typedef struct packed {
    logic [7:0] sym;
    logic       lst;
    logic       fixed;
    dec_word_t  want;
  } dir_row_t;

  localparam int NumDir = 22;
  localparam int NumItems = 800;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] symbol_i = 8'h00;
  logic       last_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       is_last_o;
  logic [1:0] status_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  base64_strict_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .symbol_i     (symbol_i),
    .last_i       (last_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .is_last_o    (is_last_o),
    .status_o     (status_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decoder state mirror
  logic [11:0] acc_bits = '0;
  logic [2:0]  bits_held = '0;
  logic [1:0]  content_ph = '0;
  logic [1:0]  total_ph = '0;
  logic [1:0]  pad_run = '0;
  logic        saw_bad = 1'b0;

  dec_word_t pending_words [$];
  int        mismatches = 0;
  int        chars_sent = 0;
  logic      quiet = 1'b0;
  int        rx_stall = 0;

  dir_row_t dir_tbl [0:NumDir-1] = '{
    '{8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::STATUS_BAD_LEN}},
    '{"=",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::STATUS_BAD_PAD}},
    '{"/",   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, b64d_pkg::STATUS_OK}},
    '{"/",   1'b0, 1'b1, '{8'hff, 1'b1, 1'b0, b64d_pkg::STATUS_OK}},
    '{"/",   1'b0, 1'b1, '{8'hff, 1'b1, 1'b0, b64d_pkg::STATUS_OK}},
    '{"/",   1'b1, 1'b1, '{8'hff, 1'b1, 1'b1, b64d_pkg::STATUS_OK}},
    '{"+",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{"z",   1'b0, 1'b0, '0},
    '{"=",   1'b1, 1'b0, '0},
    '{"A",   1'b0, 1'b0, '0},
    '{"=",   1'b0, 1'b0, '0},
    '{"=",   1'b0, 1'b0, '0},
    '{"=",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::STATUS_BAD_PAD}},
    '{"A",   1'b0, 1'b0, '0},
    '{"B",   1'b1, 1'b0, '0},
    '{"a",   1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{"0",   1'b0, 1'b0, '0},
    '{"=",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::STATUS_BAD_CHAR}},
    '{"=",   1'b0, 1'b0, '0},
    '{"A",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::STATUS_BAD_CHAR}}
  };

  function automatic int char_to_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == b64d_pkg::CharPlus) return 62;
    if (c == b64d_pkg::CharSlash) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? b64d_pkg::CharPlus : b64d_pkg::CharSlash;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic lst, output dec_word_t w);
    int          sx;
    logic [11:0] acc;
    logic [3:0]  n;
    w = '{8'h00, 1'b0, lst, b64d_pkg::STATUS_OK};
    total_ph = total_ph + 2'd1;
    if (c == b64d_pkg::CharPad) begin
      if (pad_run != 2'd3) pad_run = pad_run + 2'd1;
    end else begin
      // a pad run followed by content means '=' inside the text
      if (pad_run != 2'd0) saw_bad = 1'b1;
      pad_run = 2'd0;
      content_ph = total_ph;
      sx = char_to_sextet(c);
      if (sx < 0) begin
        saw_bad = 1'b1;
      end else begin
        acc = {acc_bits[5:0], 6'(sx)};
        n = 4'(bits_held) + 4'd6;
        if (n >= 4'd8) begin
          n = n - 4'd8;
          w.data = 8'(acc >> n);
          w.bv = 1'b1;
        end
        acc_bits = acc;
        bits_held = n[2:0];
      end
    end
    if (lst) begin
      if (pad_run > 2'd2 || (pad_run != 2'd0 && total_ph != 2'd0))
        w.st = b64d_pkg::STATUS_BAD_PAD;
      else if (content_ph == 2'd1) w.st = b64d_pkg::STATUS_BAD_LEN;
      else if (saw_bad) w.st = b64d_pkg::STATUS_BAD_CHAR;
      acc_bits = '0;
      bits_held = '0;
      content_ph = '0;
      total_ph = '0;
      pad_run = '0;
      saw_bad = 1'b0;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic lst, input logic fixed,
                           input dec_word_t want);
    int        gap;
    dec_word_t w;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    symbol_i = c;
    last_i = lst;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_char(c, lst, w);
    pending_words.insert(pending_words.size(), fixed ? want : w);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      out_ready_i = 1'b0;
      rx_stall--;
    end else begin
      out_ready_i = 1'b1;
      rx_stall = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    dec_word_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{data_byte_o, byte_valid_o, is_last_o, b64d_pkg::status_e'(status_o)};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: data %h bv %b last %b status %0d",
                   data_byte_o, byte_valid_o, is_last_o, status_o);
      end else begin
        want = pending_words.pop_front();
        if (got.data !== want.data || got.bv !== want.bv || got.lst !== want.lst ||
            got.st !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                     want.data, want.bv, want.lst, want.st,
                     data_byte_o, byte_valid_o, is_last_o, status_o);
        end
      end
    end
  end

  initial begin
    int        msgs, clen, npad, k;
    logic      good;
    logic [7:0] ch;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < NumDir; k++)
      send_char(dir_tbl[k].sym, dir_tbl[k].lst, dir_tbl[k].fixed, dir_tbl[k].want);
    drain();

    msgs = 0;
    while (chars_sent < NumItems + NumDir) begin
      quiet = ($urandom_range(0, 3) == 0);
      good = ($urandom_range(0, 3) != 0);
      clen = $urandom_range(1, 9);
      if (good) begin
        if (clen % 4 == 1) clen++;
        npad = $urandom_range(0, 1) ? (4 - clen % 4) % 4 : 0;
      end else begin
        npad = $urandom_range(0, 3);
      end
      for (k = 0; k < clen + npad; k++) begin
        if (k >= clen) ch = b64d_pkg::CharPad;
        else if (!good && $urandom_range(0, 3) == 0) ch = 8'($urandom_range(0, 255));
        else ch = sextet_to_char(6'($urandom_range(0, 63)));
        send_char(ch, k == clen + npad - 1, 1'b0, '0);
      end
      msgs++;
      if (msgs % 40 == 0) drain();
    end
    drain();
    repeat (8) @(negedge clk_i);

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
